[design/osq_pkg.sv]
// ----------------------------------------------------------------------------
// osq_pkg
// shared types, register indexes and the switch level decoder for the
// override sensor qualifier
// ----------------------------------------------------------------------------
package osq_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MV_W     = 12;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DEBOUNCE = 2'd2;

  // register reset values
  localparam logic [MV_W-1:0]   THRESHOLD_RST = 12'd500;
  localparam logic [HOLD_W-1:0] REARM_RST     = 16'd500;
  localparam logic [HOLD_W-1:0] DEBOUNCE_RST  = 16'd50;

  typedef enum logic [1:0] {
    SW_NEUTRAL = 2'd0,
    SW_FORWARD = 2'd1,
    SW_REVERSE = 2'd2,
    SW_INVALID = 2'd3
  } sw_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [MV_W-1:0]   pedal_volt;
    logic              dir_level;
    logic              rev_level;
  } in_word_t;

  typedef struct packed {
    logic              pedal_pressed;
    logic              pedal_rearmed;
    logic [1:0]        switch_state;
    logic [1:0]        switch_state_raw;
    logic              dir_on;
    logic              rev_on;
  } out_word_t;

  typedef struct packed {
    logic [MV_W-1:0]   pedal_threshold_mv;
    logic [HOLD_W-1:0] rearm_hold_ms;
    logic [HOLD_W-1:0] switch_debounce_ms;
  } cfg_t;

  // active flags to switch state
  function automatic sw_state_t decode_levels(input logic d_act, input logic r_act);
    sw_state_t st;
    case ({d_act, r_act})
      2'b10:   st = SW_FORWARD;
      2'b11:   st = SW_REVERSE;
      2'b00:   st = SW_NEUTRAL;
      default: st = SW_INVALID;
    endcase
    return st;
  endfunction

endpackage

[design/osq_in_if.sv]
// ----------------------------------------------------------------------------
// osq_in_if
// sensor sample channel: valid/ready handshake with the sample fields
// ----------------------------------------------------------------------------
interface osq_in_if
  import osq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [MV_W-1:0]   pedal_volt;
  logic              dir_level;
  logic              rev_level;

  modport source (output valid, output now_ms, output pedal_volt, output dir_level,
                  output rev_level, input ready);
  modport sink   (input valid, input now_ms, input pedal_volt, input dir_level,
                  input rev_level, output ready);
endinterface

[design/osq_out_if.sv]
// ----------------------------------------------------------------------------
// osq_out_if
// qualified status channel: valid/ready handshake with the status fields
// ----------------------------------------------------------------------------
interface osq_out_if;
  logic       valid;
  logic       ready;
  logic       pedal_pressed;
  logic       pedal_rearmed;
  logic [1:0] switch_state;
  logic [1:0] switch_state_raw;
  logic       dir_on;
  logic       rev_on;

  modport source (output valid, output pedal_pressed, output pedal_rearmed,
                  output switch_state, output switch_state_raw, output dir_on,
                  output rev_on, input ready);
  modport sink   (input valid, input pedal_pressed, input pedal_rearmed,
                  input switch_state, input switch_state_raw, input dir_on,
                  input rev_on, output ready);
endinterface

[design/osq_core.sv]
// ----------------------------------------------------------------------------
// osq_core
// pedal re-arm timer and switch debouncer; state advances on en
// ----------------------------------------------------------------------------
module osq_core
  import osq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t res
);

  logic              seeded_r;
  logic              pedal_was_pressed_r, pedal_was_pressed_nxt;
  logic              release_timing_r, release_timing_nxt;
  logic [TIME_W-1:0] release_start_ms_r, release_start_ms_nxt;
  sw_state_t         stable_state_r, stable_state_nxt;
  sw_state_t         pending_state_r, pending_state_nxt;
  logic              debouncing_r, debouncing_nxt;
  logic [TIME_W-1:0] change_start_ms_r, change_start_ms_nxt;

  logic              d_act, r_act, pressed;
  sw_state_t         raw;
  // seeded views of the state
  logic              pwp_s, rt_s, deb_s;
  logic [TIME_W-1:0] rs_s;
  sw_state_t         stable_s, pending_s;
  logic              rt_mid;
  logic [TIME_W-1:0] rs_mid;
  logic [TIME_W-1:0] release_age, change_age;

  always_comb begin
    d_act   = ~item.dir_level;
    r_act   = ~item.rev_level;
    raw     = decode_levels(d_act, r_act);
    pressed = item.pedal_volt >= cfg.pedal_threshold_mv;

    // first word after reset seeds the state
    stable_s  = seeded_r ? stable_state_r     : raw;
    pending_s = seeded_r ? pending_state_r    : raw;
    deb_s     = seeded_r & debouncing_r;
    pwp_s     = seeded_r ? pedal_was_pressed_r : pressed;
    rt_s      = seeded_r & release_timing_r;
    rs_s      = seeded_r ? release_start_ms_r : '0;

    // pedal re-arm
    rt_mid = rt_s;
    rs_mid = rs_s;
    if (!pressed && pwp_s && !rt_s) begin
      rt_mid = 1'b1;
      rs_mid = item.now_ms;
    end
    release_age           = item.now_ms - rs_mid;
    release_start_ms_nxt  = rs_mid;
    if (pressed) begin
      pedal_was_pressed_nxt = 1'b1;
      release_timing_nxt    = 1'b0;
    end else if (rt_mid && (release_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.rearm_hold_ms})) begin
      pedal_was_pressed_nxt = 1'b0;
      release_timing_nxt    = 1'b0;
    end else begin
      pedal_was_pressed_nxt = pwp_s;
      release_timing_nxt    = rt_mid;
    end

    // switch debounce
    change_age          = item.now_ms - change_start_ms_r;
    stable_state_nxt    = stable_s;
    pending_state_nxt   = pending_s;
    debouncing_nxt      = deb_s;
    change_start_ms_nxt = change_start_ms_r;
    if (raw != stable_s) begin
      if (!deb_s || (raw != pending_s)) begin
        pending_state_nxt   = raw;
        change_start_ms_nxt = item.now_ms;
        debouncing_nxt      = 1'b1;
      end else if (change_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.switch_debounce_ms}) begin
        stable_state_nxt = pending_s;
        debouncing_nxt   = 1'b0;
      end
    end else begin
      debouncing_nxt = 1'b0;
    end

    res.pedal_pressed    = pressed;
    res.pedal_rearmed    = ~pressed & ~pedal_was_pressed_nxt;
    res.switch_state     = stable_state_nxt;
    res.switch_state_raw = raw;
    res.dir_on           = d_act;
    res.rev_on           = r_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r            <= 1'b0;
      pedal_was_pressed_r <= 1'b0;
      release_timing_r    <= 1'b0;
      release_start_ms_r  <= '0;
      stable_state_r      <= SW_NEUTRAL;
      pending_state_r     <= SW_NEUTRAL;
      debouncing_r        <= 1'b0;
      change_start_ms_r   <= '0;
    end else if (en) begin
      seeded_r            <= 1'b1;
      pedal_was_pressed_r <= pedal_was_pressed_nxt;
      release_timing_r    <= release_timing_nxt;
      release_start_ms_r  <= release_start_ms_nxt;
      stable_state_r      <= stable_state_nxt;
      pending_state_r     <= pending_state_nxt;
      debouncing_r        <= debouncing_nxt;
      change_start_ms_r   <= change_start_ms_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seed_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> seeded_r)
    else $error("state not seeded after first word");

  a_release_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    release_timing_r |-> pedal_was_pressed_r)
    else $error("re-arm timer running without a press");

  a_pending_differs: assert property (@(posedge clk) disable iff (!rst_n)
    debouncing_r |-> (pending_state_r != stable_state_r))
    else $error("debounce target equals stable state");

  a_press_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (en && pressed) |=> (pedal_was_pressed_r && !release_timing_r))
    else $error("press not latched");
`endif

endmodule

[design/override_sensor_qualifier.sv]
// ----------------------------------------------------------------------------
// override_sensor_qualifier
// qualifies pedal and direction switch samples for the override path
// ----------------------------------------------------------------------------
// path: input register, then core update into the output register once it is free
// throughput: one word per cycle while the sink stays ready; the whole update is one
//   pass from the input register through the re-arm timer and debouncer compares
//   into the output register
// reset: rst_n is synchronous; registers return to 500 mV, 500 ms and 50 ms,
//   and the first word after reset seeds the switch state and pressed flag
module override_sensor_qualifier
  import osq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  osq_in_if.sink                in_word,
  osq_out_if.source             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // config registers
  cfg_t      cfg_r;

  // input register stage
  logic      in_valid_r;
  in_word_t  in_data_r;

  // result register stage
  logic      out_valid_r;
  out_word_t out_data_r;

  out_word_t core_res;
  logic      advance;   // input stage word moves into the result register
  logic      in_fire;

  // the result register frees when the sink takes the word or it is empty
  assign advance       = in_valid_r & (~out_valid_r | out_word.ready);
  assign in_word.ready = ~in_valid_r | advance;
  assign in_fire       = in_word.valid & in_word.ready;

  // register writes, index past the last one is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pedal_threshold_mv <= THRESHOLD_RST;
      cfg_r.rearm_hold_ms      <= REARM_RST;
      cfg_r.switch_debounce_ms <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PEDAL_THRESHOLD: cfg_r.pedal_threshold_mv <= cfg_wdata[MV_W-1:0];
        CFG_REARM_HOLD:      cfg_r.rearm_hold_ms      <= cfg_wdata[HOLD_W-1:0];
        CFG_SWITCH_DEBOUNCE: cfg_r.switch_debounce_ms <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      in_valid_r <= in_word.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r.now_ms     <= in_word.now_ms;
      in_data_r.pedal_volt <= in_word.pedal_volt;
      in_data_r.dir_level  <= in_word.dir_level;
      in_data_r.rev_level  <= in_word.rev_level;
    end
  end

  // timer and debounce state update
  osq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (in_data_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= core_res;
    end
  end

  assign out_word.valid            = out_valid_r;
  assign out_word.pedal_pressed    = out_data_r.pedal_pressed;
  assign out_word.pedal_rearmed    = out_data_r.pedal_rearmed;
  assign out_word.switch_state     = out_data_r.switch_state;
  assign out_word.switch_state_raw = out_data_r.switch_state_raw;
  assign out_word.dir_on           = out_data_r.dir_on;
  assign out_word.rev_on           = out_data_r.rev_on;

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("input stage word lost");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> $stable(in_data_r))
    else $error("input stage word changed while stalled");

  a_rearm_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.pedal_rearmed && out_data_r.pedal_pressed))
    else $error("re-armed while pressed");
`endif

endmodule

[verif/override_sensor_qualifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// override_sensor_qualifier_tb
// self-checking bench for the override sensor qualifier: a queue-fed driver
// pushes sensor words under random idling, a sample-level predictor computes
// the status word each accepted sample should produce, and a monitor checks
// every status word field by field across several register settings
// ----------------------------------------------------------------------------
module override_sensor_qualifier_tb;
  import osq_pkg::*;

  // pin level pairs {dir_level, rev_level}, both active low
  localparam logic [1:0] LV_NEUTRAL = 2'b11;
  localparam logic [1:0] LV_FORWARD = 2'b01;
  localparam logic [1:0] LV_REVERSE = 2'b00;
  localparam logic [1:0] LV_INVALID = 2'b10;

  // index past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  osq_in_if  in_ch ();
  osq_out_if out_ch ();

  override_sensor_qualifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_ch),
    .out_word  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // samples waiting for the driver, status words waiting for the monitor
  in_word_t  sample_queue[$];
  out_word_t expected_status[$];

  // random idling on both sides; cleared for the long no-idle stretch
  bit throttle = 1'b1;

  int mismatch_count = 0;
  int word_no = 0;

  // predictor copy of the registers
  logic [MV_W-1:0]   thr_mv      = THRESHOLD_RST;
  logic [HOLD_W-1:0] hold_ms     = REARM_RST;
  logic [HOLD_W-1:0] debounce_ms = DEBOUNCE_RST;

  // predictor copy of the qualifier state
  logic              seeded         = 1'b0;
  logic              pedal_latched  = 1'b0;
  logic              release_timing = 1'b0;
  logic [TIME_W-1:0] release_start  = '0;
  sw_state_t         stable_sw      = SW_NEUTRAL;
  sw_state_t         pending_sw     = SW_NEUTRAL;
  logic              debouncing     = 1'b0;
  logic [TIME_W-1:0] change_start   = '0;

  // stimulus generator state
  logic [TIME_W-1:0] sample_clock_ms = '0;
  logic [1:0]        held_levels     = LV_NEUTRAL;
  bit                pedal_down      = 1'b0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor: advances the qualifier state by one sample, returns the status
  // --------------------------------------------------------------------------
  function automatic out_word_t qualify(in_word_t w);
    logic              d_act;
    logic              r_act;
    logic              pressed;
    logic [TIME_W-1:0] released_for;
    logic [TIME_W-1:0] settled_for;
    sw_state_t         raw;
    out_word_t         r;
    d_act = !w.dir_level;
    r_act = !w.rev_level;
    // reverse alone (without direction) is the invalid combination
    if (d_act) raw = r_act ? SW_REVERSE : SW_FORWARD;
    else       raw = r_act ? SW_INVALID : SW_NEUTRAL;
    pressed = (w.pedal_volt >= thr_mv);

    // first sample after reset seeds the debouncer and the press latch
    if (!seeded) begin
      stable_sw      = raw;
      pending_sw     = raw;
      debouncing     = 1'b0;
      pedal_latched  = pressed;
      release_timing = 1'b0;
      release_start  = '0;
      seeded         = 1'b1;
    end

    // re-arm: timer starts at the first released sample after a press
    if (pressed) begin
      pedal_latched  = 1'b1;
      release_timing = 1'b0;
    end else begin
      if (pedal_latched && !release_timing) begin
        release_timing = 1'b1;
        release_start  = w.now_ms;
      end
      released_for = w.now_ms - release_start;
      if (release_timing && released_for >= hold_ms) begin
        pedal_latched  = 1'b0;
        release_timing = 1'b0;
      end
    end

    // debounce with restartable target
    settled_for = w.now_ms - change_start;
    if (raw != stable_sw) begin
      if (!debouncing) begin
        pending_sw   = raw;
        change_start = w.now_ms;
        debouncing   = 1'b1;
      end else if (raw != pending_sw) begin
        pending_sw   = raw;
        change_start = w.now_ms;
      end else if (settled_for >= debounce_ms) begin
        stable_sw  = pending_sw;
        debouncing = 1'b0;
      end
    end else begin
      debouncing = 1'b0;
    end

    r.pedal_pressed    = pressed;
    r.pedal_rearmed    = !pressed && !pedal_latched;
    r.switch_state     = stable_sw;
    r.switch_state_raw = raw;
    r.dir_on           = d_act;
    r.rev_on           = r_act;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // driver: holds valid until the word is taken, predicts at acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_word_t nxt;
    logic     load;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.now_ms     <= '0;
      in_ch.pedal_volt <= '0;
      in_ch.dir_level  <= 1'b1;
      in_ch.rev_level  <= 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_status.push_back(qualify({in_ch.now_ms, in_ch.pedal_volt,
                                           in_ch.dir_level, in_ch.rev_level}));
      // the slot is free when nothing is shown or the shown word just went
      if (!in_ch.valid || in_ch.ready) begin
        load = (sample_queue.size() != 0) && !(throttle && $urandom_range(99) < 30);
        if (load) begin
          nxt = sample_queue.pop_front();
          in_ch.now_ms     <= nxt.now_ms;
          in_ch.pedal_volt <= nxt.pedal_volt;
          in_ch.dir_level  <= nxt.dir_level;
          in_ch.rev_level  <= nxt.rev_level;
        end
        in_ch.valid <= load;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each taken status word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pedal_pressed, out_ch.pedal_rearmed, out_ch.switch_state,
               out_ch.switch_state_raw, out_ch.dir_on, out_ch.rev_on};
        if (expected_status.size() == 0) begin
          flag_mismatch($sformatf("status word %0d with nothing expected", word_no));
        end else begin
          want = expected_status.pop_front();
          if (got.pedal_pressed !== want.pedal_pressed)
            flag_mismatch($sformatf("word %0d pedal_pressed got %0b want %0b",
                                    word_no, got.pedal_pressed, want.pedal_pressed));
          if (got.pedal_rearmed !== want.pedal_rearmed)
            flag_mismatch($sformatf("word %0d pedal_rearmed got %0b want %0b",
                                    word_no, got.pedal_rearmed, want.pedal_rearmed));
          if (got.switch_state !== want.switch_state)
            flag_mismatch($sformatf("word %0d switch_state got %0d want %0d",
                                    word_no, got.switch_state, want.switch_state));
          if (got.switch_state_raw !== want.switch_state_raw)
            flag_mismatch($sformatf("word %0d switch_state_raw got %0d want %0d",
                                    word_no, got.switch_state_raw, want.switch_state_raw));
          if (got.dir_on !== want.dir_on)
            flag_mismatch($sformatf("word %0d dir_on got %0b want %0b",
                                    word_no, got.dir_on, want.dir_on));
          if (got.rev_on !== want.rev_on)
            flag_mismatch($sformatf("word %0d rev_on got %0b want %0b",
                                    word_no, got.rev_on, want.rev_on));
        end
        word_no++;
      end
      out_ch.ready <= !throttle || ($urandom_range(99) >= 30);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_sample(input logic [TIME_W-1:0] now, input logic [MV_W-1:0] mv,
                            input logic [1:0] levels);
    in_word_t w;
    w.now_ms     = now;
    w.pedal_volt = mv;
    w.dir_level  = levels[1];
    w.rev_level  = levels[0];
    sample_queue.push_back(w);
  endtask

  // everything sent, everything checked, then a settling wait
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_ch.valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write, only called while the qualifier is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PEDAL_THRESHOLD: thr_mv      = val[MV_W-1:0];
      CFG_REARM_HOLD:      hold_ms     = val;
      CFG_SWITCH_DEBOUNCE: debounce_ms = val;
      default: ;
    endcase
  endtask

  // mostly held switch positions and press/release runs with random timing,
  // plus single-sample bounces, threshold-edge values and big time jumps
  task automatic run_stream(input int n, input int unsigned step_max);
    int unsigned      pick;
    logic [1:0]       levels;
    logic [MV_W-1:0]  mv;
    logic [TIME_W-1:0] step;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) held_levels = 2'($urandom_range(3));
      levels = (pick >= 12 && pick < 18) ? 2'($urandom_range(3)) : held_levels;

      if ($urandom_range(99) < 10) pedal_down = !pedal_down;
      case ($urandom_range(9))
        0:       mv = 12'($urandom_range(4095));
        1:       mv = thr_mv;
        2:       mv = (thr_mv == 0) ? '0 : thr_mv - 1'b1;
        default: begin
          if (pedal_down)        mv = 12'($urandom_range(4095, thr_mv));
          else if (thr_mv == 0)  mv = '0;
          else                   mv = 12'($urandom_range(thr_mv - 1, 0));
        end
      endcase

      pick = $urandom_range(99);
      if (pick < 3)       step = $urandom;
      else if (pick < 13) step = '0;
      else                step = $urandom_range(step_max);
      sample_clock_ms += step;
      add_sample(sample_clock_ms, mv, levels);
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_we          = 1'b0;
    cfg_idx         = CFG_PEDAL_THRESHOLD;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values (500 mV, 500 ms, 50 ms)
    add_sample(32'd0,   12'd4095, LV_FORWARD);  // seeds forward and pressed
    add_sample(32'd10,  12'd0,    LV_FORWARD);  // release timer starts
    add_sample(32'd509, 12'd499,  LV_FORWARD);  // one ms short, just below threshold
    add_sample(32'd510, 12'd0,    LV_FORWARD);  // hold met, re-armed
    add_sample(32'd520, 12'd500,  LV_NEUTRAL);  // at threshold, debounce toward neutral
    add_sample(32'd540, 12'd0,    LV_REVERSE);  // new target restarts the timer
    add_sample(32'd589, 12'd0,    LV_REVERSE);  // one ms short of debounce
    add_sample(32'd590, 12'd0,    LV_REVERSE);  // accepted
    add_sample(32'd600, 12'd0,    LV_INVALID);  // rev alone, debounce starts
    add_sample(32'd610, 12'd0,    LV_REVERSE);  // back to stable cancels it
    add_sample(32'd700, 12'd0,    LV_INVALID);
    // timestamps wrapping through zero for both timers
    add_sample(32'hFFFF_FFE0, 12'd4095, LV_NEUTRAL);
    add_sample(32'hFFFF_FFF0, 12'd0,    LV_NEUTRAL);
    add_sample(32'h0000_0011, 12'd0,    LV_NEUTRAL);  // 49 ms across the wrap
    add_sample(32'h0000_0012, 12'd0,    LV_NEUTRAL);  // 50 ms, accepted
    add_sample(32'h0000_01E3, 12'd0,    LV_NEUTRAL);  // 499 ms released
    add_sample(32'h0000_01E4, 12'd0,    LV_NEUTRAL);  // 500 ms, re-armed
    add_sample(32'hFFFF_FFFF, 12'd4095, LV_FORWARD);
    wait_idle();

    // directed, top threshold with zero hold and zero debounce
    write_reg(CFG_PEDAL_THRESHOLD, 16'd4095);
    write_reg(CFG_REARM_HOLD,      16'd0);
    write_reg(CFG_SWITCH_DEBOUNCE, 16'd0);
    add_sample(32'd100, 12'd4095, LV_NEUTRAL);  // pressed only at full scale
    add_sample(32'd101, 12'd4094, LV_NEUTRAL);  // zero hold re-arms at once
    add_sample(32'd101, 12'd0,    LV_FORWARD);  // debounce starts
    add_sample(32'd101, 12'd0,    LV_FORWARD);  // accepted on the second word
    sample_clock_ms = 32'd200;
    run_stream(250, 3);
    wait_idle();

    // zero threshold, longest hold and debounce, wide time steps
    write_reg(CFG_PEDAL_THRESHOLD, 16'd0);
    write_reg(CFG_REARM_HOLD,      16'hFFFF);
    write_reg(CFG_SWITCH_DEBOUNCE, 16'hFFFF);
    run_stream(250, 30000);
    wait_idle();

    // random mid settings, upper threshold bits and the unused index,
    // sent as one long stretch without idling on either side
    write_reg(CFG_PEDAL_THRESHOLD, 16'($urandom_range(65535)));
    write_reg(CFG_REARM_HOLD,      16'($urandom_range(1000, 1)));
    write_reg(CFG_SWITCH_DEBOUNCE, 16'($urandom_range(200, 1)));
    write_reg(CFG_UNUSED,          16'($urandom_range(65535)));
    throttle = 1'b0;
    run_stream(400, 60);
    wait_idle();
    throttle = 1'b1;

    // typical settings while the time base wraps
    write_reg(CFG_PEDAL_THRESHOLD, 16'd2048);
    write_reg(CFG_REARM_HOLD,      16'd300);
    write_reg(CFG_SWITCH_DEBOUNCE, 16'd40);
    sample_clock_ms = 32'hFFFF_F000;
    run_stream(450, 120);
    wait_idle();

    // drain window for any stray status word
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
design/osq_pkg.sv
design/osq_in_if.sv
design/osq_out_if.sv
design/osq_core.sv
design/override_sensor_qualifier.sv
verif/override_sensor_qualifier_tb.sv
